### src/cpo_pkg.sv
// Shared widths, codes, pipeline payload types and saturation for the push-out block.
package cpo_pkg;

   localparam int COORD_W    = 32;
   localparam int SIZE_W     = COORD_W - 1;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int COMP_W     = COORD_W + 3;
   localparam int MAG_W      = COORD_W + 2;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int D2_W       = SQ_W + 1;
   localparam int RAD_W      = COORD_W + 1;
   localparam int RL2_W      = 2 * RAD_W;
   localparam int ROOT_W     = RAD_W;
   localparam int RADICAND_W = 2 * ROOT_W;
   localparam int SQREM_W    = ROOT_W + 2;
   localparam int NUM_W      = 2 * RAD_W;
   localparam int QUO_W      = RAD_W + 1;
   localparam int DIV_W      = RAD_W + 2;
   localparam int BB_W       = COORD_W + 1;
   localparam int SUM_W      = QUO_W + 2;

   // squared-distance floors at or below which no push happens (0.0001 / 0.01 units)
   localparam logic [D2_W-1:0] CC_MIN_D2 = D2_W'(42);
   localparam logic [D2_W-1:0] CB_MIN_D2 = D2_W'(1717986);

   localparam logic [SUM_W-1:0] SAT_MAX = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
   localparam logic [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

   typedef enum logic [1:0] {
      MODE_CC,
      MODE_BB,
      MODE_CB
   } mode_type;

   // coordinates are held in circle / other-shape roles; swap maps them back
   typedef struct packed {
      logic [COORD_W-1:0] c_x;
      logic [COORD_W-1:0] c_y;
      logic [COORD_W-1:0] k_x;
      logic [COORD_W-1:0] k_y;
      logic               swap;
      logic               mov_c;
      logic               mov_k;
      mode_type           mode;
      logic [BB_W-1:0]    bb_x;
      logic [BB_W-1:0]    bb_y;
   } side_type;

   typedef struct packed {
      logic             push;
      logic             neg_x;
      logic             neg_y;
      logic [RAD_W-1:0] mag_x;
      logic [RAD_W-1:0] mag_y;
      logic [RAD_W-1:0] rlim;
   } geo_type;

   typedef struct packed {
      side_type side;
      geo_type  geo;
   } sq_pay_type;

   typedef struct packed {
      side_type side;
      logic     push;
      logic     neg_x;
      logic     neg_y;
   } dv_pay_type;

   function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
      logic [COORD_W-1:0] r;
      if ($signed(v) > $signed(SAT_MAX)) begin
         r = SAT_MAX[COORD_W-1:0];
      end else if ($signed(v) < $signed(SAT_MIN)) begin
         r = SAT_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

### src/cpo_front.sv
// Front stages: role decode, component extraction, squaring and overlap test.
module cpo_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_vld,
   input  logic                                  shape_a,
   input  logic                                  shape_b,
   input  logic signed [cpo_pkg::COORD_W-1:0]    a_x,
   input  logic signed [cpo_pkg::COORD_W-1:0]    a_y,
   input  logic signed [cpo_pkg::COORD_W-1:0]    b_x,
   input  logic signed [cpo_pkg::COORD_W-1:0]    b_y,
   input  logic [cpo_pkg::SIZE_W-1:0]            a_w,
   input  logic [cpo_pkg::SIZE_W-1:0]            a_h,
   input  logic [cpo_pkg::SIZE_W-1:0]            b_w,
   input  logic [cpo_pkg::SIZE_W-1:0]            b_h,
   input  logic                                  mov_a,
   input  logic                                  mov_b,
   output logic                                  out_vld,
   output logic [cpo_pkg::RADICAND_W-1:0]        out_rad,
   output cpo_pkg::sq_pay_type                   out_pay
);

   // stage 1: roles and raw differences
   logic                                 s1_vld_ff;
   cpo_pkg::mode_type                    s1_mode_ff, s1_mode_in;
   logic                                 s1_swap_ff, s1_swap_in;
   logic                                 s1_mov_c_ff, s1_mov_c_in, s1_mov_k_ff, s1_mov_k_in;
   logic signed [cpo_pkg::COORD_W-1:0]   s1_c_x_ff, s1_c_y_ff, s1_k_x_ff, s1_k_y_ff;
   logic signed [cpo_pkg::COORD_W-1:0]   s1_c_x_in, s1_c_y_in, s1_k_x_in, s1_k_y_in;
   logic [cpo_pkg::SIZE_W-1:0]           s1_c_w_ff, s1_c_h_ff, s1_k_w_ff, s1_k_h_ff;
   logic [cpo_pkg::SIZE_W-1:0]           s1_c_w_in, s1_c_h_in, s1_k_w_in, s1_k_h_in;
   logic signed [cpo_pkg::DIFF_W-1:0]    s1_e_x_ff, s1_e_y_ff, s1_e_x_in, s1_e_y_in;

   always_comb begin
      s1_swap_in = shape_a & ~shape_b;
      priority if (!shape_a && !shape_b) begin
         s1_mode_in = cpo_pkg::MODE_CC;
      end else if (shape_a && shape_b) begin
         s1_mode_in = cpo_pkg::MODE_BB;
      end else begin
         s1_mode_in = cpo_pkg::MODE_CB;
      end
      s1_c_x_in   = s1_swap_in ? b_x : a_x;
      s1_c_y_in   = s1_swap_in ? b_y : a_y;
      s1_k_x_in   = s1_swap_in ? a_x : b_x;
      s1_k_y_in   = s1_swap_in ? a_y : b_y;
      s1_c_w_in   = s1_swap_in ? b_w : a_w;
      s1_c_h_in   = s1_swap_in ? b_h : a_h;
      s1_k_w_in   = s1_swap_in ? a_w : b_w;
      s1_k_h_in   = s1_swap_in ? a_h : b_h;
      s1_mov_c_in = s1_swap_in ? mov_b : mov_a;
      s1_mov_k_in = s1_swap_in ? mov_a : mov_b;
      s1_e_x_in   = $signed({s1_c_x_in[cpo_pkg::COORD_W-1], s1_c_x_in})
                  - $signed({s1_k_x_in[cpo_pkg::COORD_W-1], s1_k_x_in});
      s1_e_y_in   = $signed({s1_c_y_in[cpo_pkg::COORD_W-1], s1_c_y_in})
                  - $signed({s1_k_y_in[cpo_pkg::COORD_W-1], s1_k_y_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= in_vld;
      end
   end

   always_ff @(posedge clock) begin
      s1_mode_ff  <= s1_mode_in;
      s1_swap_ff  <= s1_swap_in;
      s1_mov_c_ff <= s1_mov_c_in;
      s1_mov_k_ff <= s1_mov_k_in;
      s1_c_x_ff   <= s1_c_x_in;
      s1_c_y_ff   <= s1_c_y_in;
      s1_k_x_ff   <= s1_k_x_in;
      s1_k_y_ff   <= s1_k_y_in;
      s1_c_w_ff   <= s1_c_w_in;
      s1_c_h_ff   <= s1_c_h_in;
      s1_k_w_ff   <= s1_k_w_in;
      s1_k_h_ff   <= s1_k_h_in;
      s1_e_x_ff   <= s1_e_x_in;
      s1_e_y_ff   <= s1_e_y_in;
   end

   // stage 2: offset from nearest box point, magnitudes, box-box push
   function automatic logic signed [cpo_pkg::COMP_W-1:0] cb_comp(
      input logic signed [cpo_pkg::DIFF_W-1:0] e,
      input logic [cpo_pkg::SIZE_W-1:0]        w
   );
      logic signed [cpo_pkg::COMP_W-1:0] t;
      logic signed [cpo_pkg::COMP_W-1:0] hw;
      logic signed [cpo_pkg::COMP_W-1:0] r;
      t  = $signed({{(cpo_pkg::COMP_W-cpo_pkg::DIFF_W-1){e[cpo_pkg::DIFF_W-1]}}, e, 1'b0});
      hw = $signed({{(cpo_pkg::COMP_W-cpo_pkg::SIZE_W){1'b0}}, w});
      if (t < -hw) begin
         r = t + hw;
      end else if (t > hw) begin
         r = t - hw;
      end else begin
         r = '0;
      end
      return r;
   endfunction

   function automatic logic [cpo_pkg::BB_W-1:0] bb_push(
      input logic signed [cpo_pkg::COMP_W-1:0] pen,
      input logic                              both,
      input logic signed [cpo_pkg::DIFF_W-1:0] e
   );
      logic signed [cpo_pkg::COMP_W-1:0] s;
      logic [cpo_pkg::BB_W-1:0]          r;
      s = both ? (pen >>> 2) : (pen >>> 1);
      r = s[cpo_pkg::BB_W-1:0];
      if (e <= 0) begin
         r = -r;
      end
      return r;
   endfunction

   logic signed [cpo_pkg::COMP_W-1:0] s2_comp_x, s2_comp_y;
   logic signed [cpo_pkg::COMP_W-1:0] s2_abs_x, s2_abs_y;
   logic [cpo_pkg::DIFF_W-1:0]        s2_emag_x, s2_emag_y;
   logic signed [cpo_pkg::COMP_W-1:0] s2_pen_x, s2_pen_y;
   logic [cpo_pkg::COORD_W-1:0]       s2_wsum, s2_hsum;
   logic                              s2_hit;

   logic                          s2_vld_ff;
   cpo_pkg::side_type             s2_side_ff, s2_side_in;
   logic [cpo_pkg::MAG_W-1:0]     s2_mag_x_ff, s2_mag_y_ff, s2_mag_x_in, s2_mag_y_in;
   logic                          s2_neg_x_ff, s2_neg_y_ff;
   logic [cpo_pkg::RAD_W-1:0]     s2_rlim_ff, s2_rlim_in;

   always_comb begin
      if (s1_mode_ff == cpo_pkg::MODE_CB) begin
         s2_comp_x = cb_comp(s1_e_x_ff, s1_k_w_ff);
         s2_comp_y = cb_comp(s1_e_y_ff, s1_k_h_ff);
      end else begin
         s2_comp_x = $signed({{(cpo_pkg::COMP_W-cpo_pkg::DIFF_W){s1_e_x_ff[cpo_pkg::DIFF_W-1]}},
                              s1_e_x_ff});
         s2_comp_y = $signed({{(cpo_pkg::COMP_W-cpo_pkg::DIFF_W){s1_e_y_ff[cpo_pkg::DIFF_W-1]}},
                              s1_e_y_ff});
      end
      s2_abs_x    = s2_comp_x[cpo_pkg::COMP_W-1] ? -s2_comp_x : s2_comp_x;
      s2_abs_y    = s2_comp_y[cpo_pkg::COMP_W-1] ? -s2_comp_y : s2_comp_y;
      s2_mag_x_in = s2_abs_x[cpo_pkg::MAG_W-1:0];
      s2_mag_y_in = s2_abs_y[cpo_pkg::MAG_W-1:0];

      // box-box penetration in half-LSB units
      s2_emag_x = s1_e_x_ff[cpo_pkg::DIFF_W-1] ? -s1_e_x_ff : s1_e_x_ff;
      s2_emag_y = s1_e_y_ff[cpo_pkg::DIFF_W-1] ? -s1_e_y_ff : s1_e_y_ff;
      s2_wsum   = {1'b0, s1_c_w_ff} + {1'b0, s1_k_w_ff};
      s2_hsum   = {1'b0, s1_c_h_ff} + {1'b0, s1_k_h_ff};
      s2_pen_x  = $signed({{(cpo_pkg::COMP_W-cpo_pkg::COORD_W){1'b0}}, s2_wsum})
                - $signed({1'b0, s2_emag_x, 1'b0});
      s2_pen_y  = $signed({{(cpo_pkg::COMP_W-cpo_pkg::COORD_W){1'b0}}, s2_hsum})
                - $signed({1'b0, s2_emag_y, 1'b0});
      s2_hit    = (s1_mode_ff == cpo_pkg::MODE_BB) && (s2_pen_x > 0) && (s2_pen_y > 0);

      s2_side_in.c_x   = s1_c_x_ff;
      s2_side_in.c_y   = s1_c_y_ff;
      s2_side_in.k_x   = s1_k_x_ff;
      s2_side_in.k_y   = s1_k_y_ff;
      s2_side_in.swap  = s1_swap_ff;
      s2_side_in.mov_c = s1_mov_c_ff;
      s2_side_in.mov_k = s1_mov_k_ff;
      s2_side_in.mode  = s1_mode_ff;
      s2_side_in.bb_x  = '0;
      s2_side_in.bb_y  = '0;
      if (s2_hit && (s2_pen_x < s2_pen_y)) begin
         s2_side_in.bb_x = bb_push(s2_pen_x, s1_mov_c_ff & s1_mov_k_ff, s1_e_x_ff);
      end else if (s2_hit) begin
         s2_side_in.bb_y = bb_push(s2_pen_y, s1_mov_c_ff & s1_mov_k_ff, s1_e_y_ff);
      end

      if (s1_mode_ff == cpo_pkg::MODE_CC) begin
         s2_rlim_in = {2'b00, s1_c_w_ff} + {2'b00, s1_k_w_ff};
      end else begin
         s2_rlim_in = {1'b0, s1_c_w_ff, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_side_ff  <= s2_side_in;
      s2_mag_x_ff <= s2_mag_x_in;
      s2_mag_y_ff <= s2_mag_y_in;
      s2_neg_x_ff <= s2_comp_x[cpo_pkg::COMP_W-1];
      s2_neg_y_ff <= s2_comp_y[cpo_pkg::COMP_W-1];
      s2_rlim_ff  <= s2_rlim_in;
   end

   // stage 3: squares
   logic                          s3_vld_ff;
   cpo_pkg::side_type             s3_side_ff;
   logic [cpo_pkg::SQ_W-1:0]      s3_sq_x_ff, s3_sq_y_ff;
   logic [cpo_pkg::RL2_W-1:0]     s3_rl2_ff;
   logic [cpo_pkg::MAG_W-1:0]     s3_mag_x_ff, s3_mag_y_ff;
   logic                          s3_neg_x_ff, s3_neg_y_ff;
   logic [cpo_pkg::RAD_W-1:0]     s3_rlim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_side_ff  <= s2_side_ff;
      s3_sq_x_ff  <= s2_mag_x_ff * s2_mag_x_ff;
      s3_sq_y_ff  <= s2_mag_y_ff * s2_mag_y_ff;
      s3_rl2_ff   <= s2_rlim_ff * s2_rlim_ff;
      s3_mag_x_ff <= s2_mag_x_ff;
      s3_mag_y_ff <= s2_mag_y_ff;
      s3_neg_x_ff <= s2_neg_x_ff;
      s3_neg_y_ff <= s2_neg_y_ff;
      s3_rlim_ff  <= s2_rlim_ff;
   end

   // stage 4: distance sum and overlap test
   logic [cpo_pkg::D2_W-1:0]       s4_d2;
   logic [cpo_pkg::D2_W-1:0]       s4_floor;
   logic                           s4_vld_ff;
   logic [cpo_pkg::RADICAND_W-1:0] s4_rad_ff;
   cpo_pkg::sq_pay_type            s4_pay_ff, s4_pay_in;

   always_comb begin
      s4_d2    = {1'b0, s3_sq_x_ff} + {1'b0, s3_sq_y_ff};
      s4_floor = (s3_side_ff.mode == cpo_pkg::MODE_CC) ? cpo_pkg::CC_MIN_D2 : cpo_pkg::CB_MIN_D2;
      s4_pay_in.side      = s3_side_ff;
      s4_pay_in.geo.push  = (s3_side_ff.mode != cpo_pkg::MODE_BB)
                          && (s4_d2 < cpo_pkg::D2_W'(s3_rl2_ff)) && (s4_d2 > s4_floor);
      s4_pay_in.geo.neg_x = s3_neg_x_ff;
      s4_pay_in.geo.neg_y = s3_neg_y_ff;
      s4_pay_in.geo.mag_x = s3_mag_x_ff[cpo_pkg::RAD_W-1:0];
      s4_pay_in.geo.mag_y = s3_mag_y_ff[cpo_pkg::RAD_W-1:0];
      s4_pay_in.geo.rlim  = s3_rlim_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_rad_ff <= s4_d2[cpo_pkg::RADICAND_W-1:0];
      s4_pay_ff <= s4_pay_in;
   end

   assign out_vld = s4_vld_ff;
   assign out_rad = s4_rad_ff;
   assign out_pay = s4_pay_ff;

endmodule

### src/cpo_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband payload.
module cpo_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_vld,
   input  logic [cpo_pkg::RADICAND_W-1:0]   in_rad,
   input  cpo_pkg::sq_pay_type              in_pay,
   output logic                             out_vld,
   output logic [cpo_pkg::ROOT_W-1:0]       out_root,
   output cpo_pkg::sq_pay_type              out_pay
);

   logic                           vld_ff  [cpo_pkg::ROOT_W];
   logic [cpo_pkg::SQREM_W-1:0]    rem_ff  [cpo_pkg::ROOT_W];
   logic [cpo_pkg::ROOT_W-1:0]     root_ff [cpo_pkg::ROOT_W];
   logic [cpo_pkg::RADICAND_W-1:0] rad_ff  [cpo_pkg::ROOT_W];
   cpo_pkg::sq_pay_type            pay_ff  [cpo_pkg::ROOT_W];

   for (genvar i = 0; i < cpo_pkg::ROOT_W; i++) begin : g_stage
      logic                           vld_prev;
      logic [cpo_pkg::SQREM_W-1:0]    rem_prev;
      logic [cpo_pkg::ROOT_W-1:0]     root_prev;
      logic [cpo_pkg::RADICAND_W-1:0] rad_prev;
      cpo_pkg::sq_pay_type            pay_prev;
      logic [cpo_pkg::SQREM_W+1:0]    cur;
      logic [cpo_pkg::SQREM_W+1:0]    trial;
      logic [cpo_pkg::SQREM_W+1:0]    diff;
      logic [cpo_pkg::SQREM_W-1:0]    rem_in;
      logic [cpo_pkg::ROOT_W-1:0]     root_in;

      if (i == 0) begin : g_first
         assign vld_prev  = in_vld;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = in_rad;
         assign pay_prev  = in_pay;
      end else begin : g_next
         assign vld_prev  = vld_ff[i-1];
         assign rem_prev  = rem_ff[i-1];
         assign root_prev = root_ff[i-1];
         assign rad_prev  = rad_ff[i-1];
         assign pay_prev  = pay_ff[i-1];
      end

      always_comb begin
         cur   = {rem_prev, rad_prev[cpo_pkg::RADICAND_W-1 -: 2]};
         trial = {2'b00, root_prev, 2'b01};
         diff  = cur - trial;
         if (cur >= trial) begin
            rem_in  = diff[cpo_pkg::SQREM_W-1:0];
            root_in = {root_prev[cpo_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = cur[cpo_pkg::SQREM_W-1:0];
            root_in = {root_prev[cpo_pkg::ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i]  <= rem_in;
         root_ff[i] <= root_in;
         rad_ff[i]  <= {rad_prev[cpo_pkg::RADICAND_W-3:0], 2'b00};
         pay_ff[i]  <= pay_prev;
      end
   end

   assign out_vld  = vld_ff[cpo_pkg::ROOT_W-1];
   assign out_root = root_ff[cpo_pkg::ROOT_W-1];
   assign out_pay  = pay_ff[cpo_pkg::ROOT_W-1];

endmodule

### src/cpo_div.sv
// Pipelined two-lane restoring divider with a shared divisor, one quotient bit per stage.
module cpo_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_vld,
   input  logic [cpo_pkg::NUM_W-1:0]     in_num_x,
   input  logic [cpo_pkg::NUM_W-1:0]     in_num_y,
   input  logic [cpo_pkg::DIV_W-1:0]     in_den,
   input  cpo_pkg::dv_pay_type           in_pay,
   output logic                          out_vld,
   output logic [cpo_pkg::QUO_W-1:0]     out_quo_x,
   output logic [cpo_pkg::QUO_W-1:0]     out_quo_y,
   output cpo_pkg::dv_pay_type           out_pay
);

   localparam int TOP_W = cpo_pkg::NUM_W - cpo_pkg::QUO_W;

   // low holds the unused numerator bits and collects quotient bits from the right
   function automatic logic [cpo_pkg::DIV_W+cpo_pkg::QUO_W-1:0] div_step(
      input logic [cpo_pkg::DIV_W-1:0] rem,
      input logic [cpo_pkg::QUO_W-1:0] low,
      input logic [cpo_pkg::DIV_W-1:0] den
   );
      logic [cpo_pkg::DIV_W:0]   cur;
      logic [cpo_pkg::DIV_W:0]   diff;
      logic [cpo_pkg::DIV_W-1:0] rem_n;
      logic                      qbit;
      cur  = {rem, low[cpo_pkg::QUO_W-1]};
      diff = cur - {1'b0, den};
      if (cur >= {1'b0, den}) begin
         rem_n = diff[cpo_pkg::DIV_W-1:0];
         qbit  = 1'b1;
      end else begin
         rem_n = cur[cpo_pkg::DIV_W-1:0];
         qbit  = 1'b0;
      end
      return {rem_n, low[cpo_pkg::QUO_W-2:0], qbit};
   endfunction

   logic                        vld_ff   [cpo_pkg::QUO_W];
   logic [cpo_pkg::DIV_W-1:0]   rem_x_ff [cpo_pkg::QUO_W];
   logic [cpo_pkg::DIV_W-1:0]   rem_y_ff [cpo_pkg::QUO_W];
   logic [cpo_pkg::QUO_W-1:0]   low_x_ff [cpo_pkg::QUO_W];
   logic [cpo_pkg::QUO_W-1:0]   low_y_ff [cpo_pkg::QUO_W];
   logic [cpo_pkg::DIV_W-1:0]   den_ff   [cpo_pkg::QUO_W];
   cpo_pkg::dv_pay_type         pay_ff   [cpo_pkg::QUO_W];

   for (genvar i = 0; i < cpo_pkg::QUO_W; i++) begin : g_stage
      logic                      vld_prev;
      logic [cpo_pkg::DIV_W-1:0] rem_x_prev, rem_y_prev, den_prev;
      logic [cpo_pkg::QUO_W-1:0] low_x_prev, low_y_prev;
      cpo_pkg::dv_pay_type       pay_prev;
      logic [cpo_pkg::DIV_W+cpo_pkg::QUO_W-1:0] step_x_in, step_y_in;

      if (i == 0) begin : g_first
         assign vld_prev   = in_vld;
         assign rem_x_prev = {{(cpo_pkg::DIV_W-TOP_W){1'b0}},
                              in_num_x[cpo_pkg::NUM_W-1:cpo_pkg::QUO_W]};
         assign rem_y_prev = {{(cpo_pkg::DIV_W-TOP_W){1'b0}},
                              in_num_y[cpo_pkg::NUM_W-1:cpo_pkg::QUO_W]};
         assign low_x_prev = in_num_x[cpo_pkg::QUO_W-1:0];
         assign low_y_prev = in_num_y[cpo_pkg::QUO_W-1:0];
         assign den_prev   = in_den;
         assign pay_prev   = in_pay;
      end else begin : g_next
         assign vld_prev   = vld_ff[i-1];
         assign rem_x_prev = rem_x_ff[i-1];
         assign rem_y_prev = rem_y_ff[i-1];
         assign low_x_prev = low_x_ff[i-1];
         assign low_y_prev = low_y_ff[i-1];
         assign den_prev   = den_ff[i-1];
         assign pay_prev   = pay_ff[i-1];
      end

      assign step_x_in = div_step(rem_x_prev, low_x_prev, den_prev);
      assign step_y_in = div_step(rem_y_prev, low_y_prev, den_prev);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_x_ff[i] <= step_x_in[cpo_pkg::DIV_W+cpo_pkg::QUO_W-1:cpo_pkg::QUO_W];
         low_x_ff[i] <= step_x_in[cpo_pkg::QUO_W-1:0];
         rem_y_ff[i] <= step_y_in[cpo_pkg::DIV_W+cpo_pkg::QUO_W-1:cpo_pkg::QUO_W];
         low_y_ff[i] <= step_y_in[cpo_pkg::QUO_W-1:0];
         den_ff[i]   <= den_prev;
         pay_ff[i]   <= pay_prev;
      end
   end

   assign out_vld   = vld_ff[cpo_pkg::QUO_W-1];
   assign out_quo_x = low_x_ff[cpo_pkg::QUO_W-1];
   assign out_quo_y = low_y_ff[cpo_pkg::QUO_W-1];
   assign out_pay   = pay_ff[cpo_pkg::QUO_W-1];

endmodule

### src/collision_push_out_2d_unit.sv
// Top level of the 2D circle / box push-out pipeline.
//
// Usage: drive start high with a request on the req_ ports; it is taken at
// every rising edge where start is high and busy is low. busy stays low:
// the pipeline takes one request per clock, back to back, without gaps.
// Each request yields exactly one result on the rsp_ ports, flagged by the
// one-cycle strobe rsp_valid, in request order. The receiver cannot stall,
// so results are never held.
// A request passes 4 front stages, 33 square-root stages, 1 multiply stage,
// 34 divider stages and 1 output stage on its way from the accepting edge to
// the edge that takes the result. Throughput: one request per cycle,
// set by the fully pipelined square root and divider, one bit per stage.
// Reset (synchronous, active high) clears every stage valid bit, so no
// strobe appears until new requests have travelled the pipe.
module collision_push_out_2d_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_shape_a,
   input  logic                                req_shape_b,
   input  logic signed [cpo_pkg::COORD_W-1:0]  req_a_x,
   input  logic signed [cpo_pkg::COORD_W-1:0]  req_a_y,
   input  logic signed [cpo_pkg::COORD_W-1:0]  req_b_x,
   input  logic signed [cpo_pkg::COORD_W-1:0]  req_b_y,
   input  logic [cpo_pkg::SIZE_W-1:0]          req_a_width_or_radius,
   input  logic [cpo_pkg::SIZE_W-1:0]          req_a_height,
   input  logic [cpo_pkg::SIZE_W-1:0]          req_b_width_or_radius,
   input  logic [cpo_pkg::SIZE_W-1:0]          req_b_height,
   input  logic                                req_movable_a,
   input  logic                                req_movable_b,
   output logic                                rsp_valid,
   output logic signed [cpo_pkg::COORD_W-1:0]  rsp_new_a_x,
   output logic signed [cpo_pkg::COORD_W-1:0]  rsp_new_a_y,
   output logic signed [cpo_pkg::COORD_W-1:0]  rsp_new_b_x,
   output logic signed [cpo_pkg::COORD_W-1:0]  rsp_new_b_y
);

   // every stage advances each cycle; nothing ever holds a request back
   assign busy = 1'b0;

   // front: decode roles, distance squared, overlap flag
   logic                           fe_vld;
   logic [cpo_pkg::RADICAND_W-1:0] fe_rad;
   cpo_pkg::sq_pay_type            fe_pay;

   cpo_front u_front (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (start & ~busy),
      .shape_a (req_shape_a),
      .shape_b (req_shape_b),
      .a_x     (req_a_x),
      .a_y     (req_a_y),
      .b_x     (req_b_x),
      .b_y     (req_b_y),
      .a_w     (req_a_width_or_radius),
      .a_h     (req_a_height),
      .b_w     (req_b_width_or_radius),
      .b_h     (req_b_height),
      .mov_a   (req_movable_a),
      .mov_b   (req_movable_b),
      .out_vld (fe_vld),
      .out_rad (fe_rad),
      .out_pay (fe_pay)
   );

   // floor square root of the distance squared
   logic                       sq_vld;
   logic [cpo_pkg::ROOT_W-1:0] sq_root;
   cpo_pkg::sq_pay_type        sq_pay;

   cpo_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (fe_vld),
      .in_rad   (fe_rad),
      .in_pay   (fe_pay),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_pay  (sq_pay)
   );

   // multiply stage: overlap, component * overlap, divisor scaled by the split
   logic [cpo_pkg::RAD_W-1:0] mul_ov;
   logic [cpo_pkg::DIV_W-1:0] mul_den_base;
   logic [cpo_pkg::DIV_W-1:0] mul_den_in;
   cpo_pkg::dv_pay_type       mul_pay_in;

   logic                      mul_vld_ff;
   logic [cpo_pkg::NUM_W-1:0] mul_num_x_ff, mul_num_y_ff;
   logic [cpo_pkg::DIV_W-1:0] mul_den_ff;
   cpo_pkg::dv_pay_type       mul_pay_ff;

   always_comb begin
      mul_ov       = sq_pay.geo.rlim - sq_root;
      mul_den_base = {2'b00, sq_root};
      // circle-box works in half units and a shared push is halved again
      unique case ({sq_pay.side.mode == cpo_pkg::MODE_CB,
                    sq_pay.side.mov_c & sq_pay.side.mov_k})
         2'b00:   mul_den_in = mul_den_base;
         2'b01:   mul_den_in = mul_den_base << 1;
         2'b10:   mul_den_in = mul_den_base << 1;
         default: mul_den_in = mul_den_base << 2;
      endcase
      mul_pay_in.side  = sq_pay.side;
      mul_pay_in.push  = sq_pay.geo.push;
      mul_pay_in.neg_x = sq_pay.geo.neg_x;
      mul_pay_in.neg_y = sq_pay.geo.neg_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else begin
         mul_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      mul_num_x_ff <= sq_pay.geo.mag_x * mul_ov;
      mul_num_y_ff <= sq_pay.geo.mag_y * mul_ov;
      mul_den_ff   <= mul_den_in;
      mul_pay_ff   <= mul_pay_in;
   end

   // push magnitudes
   logic                      dv_vld;
   logic [cpo_pkg::QUO_W-1:0] dv_quo_x, dv_quo_y;
   cpo_pkg::dv_pay_type       dv_pay;

   cpo_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (mul_vld_ff),
      .in_num_x  (mul_num_x_ff),
      .in_num_y  (mul_num_y_ff),
      .in_den    (mul_den_ff),
      .in_pay    (mul_pay_ff),
      .out_vld   (dv_vld),
      .out_quo_x (dv_quo_x),
      .out_quo_y (dv_quo_y),
      .out_pay   (dv_pay)
   );

   // output stage: sign the push, apply to movable shapes, saturate, unswap
   logic [cpo_pkg::SUM_W-1:0]   fin_p_x, fin_p_y;
   logic [cpo_pkg::SUM_W-1:0]   fin_push_x, fin_push_y;
   logic [cpo_pkg::SUM_W-1:0]   fin_dc_x, fin_dc_y, fin_dk_x, fin_dk_y;
   logic [cpo_pkg::SUM_W-1:0]   fin_c_x, fin_c_y, fin_k_x, fin_k_y;
   logic [cpo_pkg::COORD_W-1:0] fin_nc_x, fin_nc_y, fin_nk_x, fin_nk_y;

   logic                        rsp_valid_ff;
   logic [cpo_pkg::COORD_W-1:0] rsp_new_a_x_ff, rsp_new_a_y_ff, rsp_new_b_x_ff, rsp_new_b_y_ff;

   always_comb begin
      fin_p_x = {2'b00, dv_quo_x};
      fin_p_y = {2'b00, dv_quo_y};
      if (dv_pay.neg_x) begin
         fin_p_x = -fin_p_x;
      end
      if (dv_pay.neg_y) begin
         fin_p_y = -fin_p_y;
      end

      if (dv_pay.side.mode == cpo_pkg::MODE_BB) begin
         fin_push_x = {{(cpo_pkg::SUM_W-cpo_pkg::BB_W){dv_pay.side.bb_x[cpo_pkg::BB_W-1]}},
                       dv_pay.side.bb_x};
         fin_push_y = {{(cpo_pkg::SUM_W-cpo_pkg::BB_W){dv_pay.side.bb_y[cpo_pkg::BB_W-1]}},
                       dv_pay.side.bb_y};
      end else if (dv_pay.push) begin
         fin_push_x = fin_p_x;
         fin_push_y = fin_p_y;
      end else begin
         fin_push_x = '0;
         fin_push_y = '0;
      end

      fin_dc_x = dv_pay.side.mov_c ? fin_push_x : '0;
      fin_dc_y = dv_pay.side.mov_c ? fin_push_y : '0;
      fin_dk_x = dv_pay.side.mov_k ? fin_push_x : '0;
      fin_dk_y = dv_pay.side.mov_k ? fin_push_y : '0;

      fin_c_x = {{(cpo_pkg::SUM_W-cpo_pkg::COORD_W){dv_pay.side.c_x[cpo_pkg::COORD_W-1]}},
                 dv_pay.side.c_x};
      fin_c_y = {{(cpo_pkg::SUM_W-cpo_pkg::COORD_W){dv_pay.side.c_y[cpo_pkg::COORD_W-1]}},
                 dv_pay.side.c_y};
      fin_k_x = {{(cpo_pkg::SUM_W-cpo_pkg::COORD_W){dv_pay.side.k_x[cpo_pkg::COORD_W-1]}},
                 dv_pay.side.k_x};
      fin_k_y = {{(cpo_pkg::SUM_W-cpo_pkg::COORD_W){dv_pay.side.k_y[cpo_pkg::COORD_W-1]}},
                 dv_pay.side.k_y};

      fin_nc_x = cpo_pkg::sat_coord(fin_c_x + fin_dc_x);
      fin_nc_y = cpo_pkg::sat_coord(fin_c_y + fin_dc_y);
      fin_nk_x = cpo_pkg::sat_coord(fin_k_x - fin_dk_x);
      fin_nk_y = cpo_pkg::sat_coord(fin_k_y - fin_dk_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      rsp_new_a_x_ff <= dv_pay.side.swap ? fin_nk_x : fin_nc_x;
      rsp_new_a_y_ff <= dv_pay.side.swap ? fin_nk_y : fin_nc_y;
      rsp_new_b_x_ff <= dv_pay.side.swap ? fin_nc_x : fin_nk_x;
      rsp_new_b_y_ff <= dv_pay.side.swap ? fin_nc_y : fin_nk_y;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_new_a_x = rsp_new_a_x_ff;
   assign rsp_new_a_y = rsp_new_a_y_ff;
   assign rsp_new_b_x = rsp_new_b_x_ff;
   assign rsp_new_b_y = rsp_new_b_y_ff;

`ifndef SYNTHESIS
   // an overlap means the root stays strictly below the contact distance
   a_root_below_limit: assert property (@(posedge clock) disable iff (reset)
      sq_vld && sq_pay.geo.push |-> sq_root < sq_pay.geo.rlim)
      else $error("root not below contact distance on a push");

   // box pairs never take the circle push path
   a_box_no_circle_push: assert property (@(posedge clock) disable iff (reset)
      fe_vld && fe_pay.side.mode == cpo_pkg::MODE_BB |-> !fe_pay.geo.push)
      else $error("box pair flagged for circle push");

   // a fixed shape in the c role (the circle, or shape a of a same-kind pair) keeps its position
   a_fixed_circle_holds: assert property (@(posedge clock) disable iff (reset)
      dv_vld && !dv_pay.side.mov_c |-> fin_nc_x == dv_pay.side.c_x && fin_nc_y == dv_pay.side.c_y)
      else $error("fixed shape moved");

   // results leave in the cycle after the divider delivers them
   a_strobe_follows_div: assert property (@(posedge clock) disable iff (reset)
      dv_vld |=> rsp_valid)
      else $error("result strobe missing after divider output");
`endif

endmodule

### dv/tb.sv
// Self-checking testbench for the 2D circle / box push-out pipeline.
`timescale 1ns / 100ps

module tb;

   typedef bit [127:0] wide_type;

   // one request as driven onto the req_ ports
   typedef struct {
      bit                          shape_a;
      bit                          shape_b;
      logic [cpo_pkg::COORD_W-1:0] a_x;
      logic [cpo_pkg::COORD_W-1:0] a_y;
      logic [cpo_pkg::COORD_W-1:0] b_x;
      logic [cpo_pkg::COORD_W-1:0] b_y;
      logic [cpo_pkg::SIZE_W-1:0]  a_w;
      logic [cpo_pkg::SIZE_W-1:0]  a_h;
      logic [cpo_pkg::SIZE_W-1:0]  b_w;
      logic [cpo_pkg::SIZE_W-1:0]  b_h;
      bit                          mov_a;
      bit                          mov_b;
   } push_req_type;

   // corrected centres expected back for one request
   typedef struct {
      logic [cpo_pkg::COORD_W-1:0] a_x;
      logic [cpo_pkg::COORD_W-1:0] a_y;
      logic [cpo_pkg::COORD_W-1:0] b_x;
      logic [cpo_pkg::COORD_W-1:0] b_y;
   } centres_type;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PIPE_LATENCY   = 73;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic req_shape_a, req_shape_b, req_movable_a, req_movable_b;
   logic signed [cpo_pkg::COORD_W-1:0] req_a_x, req_a_y, req_b_x, req_b_y;
   logic [cpo_pkg::SIZE_W-1:0] req_a_width_or_radius, req_a_height;
   logic [cpo_pkg::SIZE_W-1:0] req_b_width_or_radius, req_b_height;
   logic rsp_valid;
   logic signed [cpo_pkg::COORD_W-1:0] rsp_new_a_x, rsp_new_a_y, rsp_new_b_x, rsp_new_b_y;

   centres_type expected_centres[$];
   int          error_count = 0;
   int          idle_pct = 0;
   int          stall_cycles = 0;

   collision_push_out_2d_unit i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_shape_a           (req_shape_a),
      .req_shape_b           (req_shape_b),
      .req_a_x               (req_a_x),
      .req_a_y               (req_a_y),
      .req_b_x               (req_b_x),
      .req_b_y               (req_b_y),
      .req_a_width_or_radius (req_a_width_or_radius),
      .req_a_height          (req_a_height),
      .req_b_width_or_radius (req_b_width_or_radius),
      .req_b_height          (req_b_height),
      .req_movable_a         (req_movable_a),
      .req_movable_b         (req_movable_b),
      .rsp_valid             (rsp_valid),
      .rsp_new_a_x           (rsp_new_a_x),
      .rsp_new_a_y           (rsp_new_a_y),
      .rsp_new_b_x           (rsp_new_b_x),
      .rsp_new_b_y           (rsp_new_b_y)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ---------------------------------------------------------------
   // Push-out arithmetic, exact on 64-bit raw values, 128-bit products
   // ---------------------------------------------------------------
   function automatic longint unsigned abs64(longint v);
      return (v < 0) ? longint'(0) - v : v;
   endfunction

   function automatic longint unsigned floor_sqrt(wide_type n);
      longint unsigned r;
      longint unsigned c;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (wide_type'(c) * wide_type'(c) <= n) r = c;
      end
      return r;
   endfunction

   // floor(|comp| * ov / div) carrying the sign of comp
   function automatic longint push_component(longint comp, longint unsigned ov,
                                             longint unsigned div);
      wide_type prod;
      longint   m;
      prod = wide_type'(abs64(comp)) * wide_type'(ov);
      m = longint'(prod / wide_type'(div));
      return (comp < 0) ? -m : m;
   endfunction

   function automatic longint clamp64(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic logic [cpo_pkg::COORD_W-1:0] saturate(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[cpo_pkg::COORD_W-1:0];
   endfunction

   // circle at (cx,cy) radius r against box at (kx,ky), full size w x h; half-LSB units
   function automatic void circle_box_push(inout longint cx, inout longint cy,
                                           input longint unsigned r, input bit mc,
                                           inout longint kx, inout longint ky,
                                           input longint w, input longint h,
                                           input bit mk);
      longint nx, ny, dx, dy, px, py;
      longint unsigned r2, root_dist, ov, div;
      wide_type d2;
      nx = clamp64(2 * cx, 2 * kx - w, 2 * kx + w);
      ny = clamp64(2 * cy, 2 * ky - h, 2 * ky + h);
      dx = 2 * cx - nx;
      dy = 2 * cy - ny;
      r2 = 2 * r;
      d2 = wide_type'(abs64(dx)) * wide_type'(abs64(dx))
         + wide_type'(abs64(dy)) * wide_type'(abs64(dy));
      if (wide_type'(r2) * wide_type'(r2) <= d2 || d2 <= wide_type'(1717986)) return;
      root_dist = floor_sqrt(d2);
      ov = r2 - root_dist;
      div = root_dist * ((mc && mk) ? 4 : 2);
      px = push_component(dx, ov, div);
      py = push_component(dy, ov, div);
      if (mc) begin
         cx += px;
         cy += py;
      end
      if (mk) begin
         kx -= px;
         ky -= py;
      end
   endfunction

   function automatic centres_type resolve_push(push_req_type r);
      longint ax, ay, bx, by, dx, dy, px, py, px2, py2, q, s;
      longint wa, ha, wb, hb;
      longint unsigned rs, root_dist, ov, div;
      wide_type d2;
      centres_type res;
      ax = longint'($signed(r.a_x));
      ay = longint'($signed(r.a_y));
      bx = longint'($signed(r.b_x));
      by = longint'($signed(r.b_y));
      wa = longint'({33'd0, r.a_w});
      ha = longint'({33'd0, r.a_h});
      wb = longint'({33'd0, r.b_w});
      hb = longint'({33'd0, r.b_h});
      if (!r.shape_a && !r.shape_b) begin
         dx = ax - bx;
         dy = ay - by;
         rs = wa + wb;
         d2 = wide_type'(abs64(dx)) * wide_type'(abs64(dx))
            + wide_type'(abs64(dy)) * wide_type'(abs64(dy));
         if (d2 < wide_type'(rs) * wide_type'(rs) && d2 > wide_type'(42)) begin
            root_dist = floor_sqrt(d2);
            ov = rs - root_dist;
            div = (r.mov_a && r.mov_b) ? 2 * root_dist : root_dist;
            px = push_component(dx, ov, div);
            py = push_component(dy, ov, div);
            if (r.mov_a) begin
               ax += px;
               ay += py;
            end
            if (r.mov_b) begin
               bx -= px;
               by -= py;
            end
         end
      end else if (r.shape_a && r.shape_b) begin
         dx = ax - bx;
         dy = ay - by;
         px2 = wa + wb - 2 * longint'(abs64(dx));
         py2 = ha + hb - 2 * longint'(abs64(dy));
         q = (r.mov_a && r.mov_b) ? 4 : 2;
         if (px2 > 0 && py2 > 0) begin
            if (px2 < py2) begin
               s = (dx > 0) ? px2 / q : -(px2 / q);
               if (r.mov_a) ax += s;
               if (r.mov_b) bx -= s;
            end else begin
               s = (dy > 0) ? py2 / q : -(py2 / q);
               if (r.mov_a) ay += s;
               if (r.mov_b) by -= s;
            end
         end
      end else if (!r.shape_a) begin
         circle_box_push(ax, ay, wa, r.mov_a, bx, by, wb, hb, r.mov_b);
      end else begin
         circle_box_push(bx, by, wb, r.mov_b, ax, ay, wa, ha, r.mov_a);
      end
      res.a_x = saturate(ax);
      res.a_y = saturate(ay);
      res.b_x = saturate(bx);
      res.b_y = saturate(by);
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Driving and checking
   // ---------------------------------------------------------------

   // Drive one request at the falling edge, hold it until taken, then queue its result.
   task automatic send_request(push_req_type r);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start                 = 1'b1;
      req_shape_a           = r.shape_a;
      req_shape_b           = r.shape_b;
      req_a_x               = r.a_x;
      req_a_y               = r.a_y;
      req_b_x               = r.b_x;
      req_b_y               = r.b_y;
      req_a_width_or_radius = r.a_w;
      req_a_height          = r.a_h;
      req_b_width_or_radius = r.b_w;
      req_b_height          = r.b_h;
      req_movable_a         = r.mov_a;
      req_movable_b         = r.mov_b;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      expected_centres.push_back(resolve_push(r));
   endtask

   // Drop start and hold off until every queued result has come back.
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (expected_centres.size() != 0) @(posedge clock);
   endtask

   task automatic report_mismatch(string what, logic [cpo_pkg::COORD_W-1:0] got,
                                  logic [cpo_pkg::COORD_W-1:0] exp);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
      error_count++;
   endtask

   // Compare each strobed result with the oldest queued expectation.
   always @(posedge clock) begin
      centres_type e;
      if (!reset && rsp_valid) begin
         if (expected_centres.size() == 0) begin
            report_mismatch("unexpected result a_x", rsp_new_a_x, 'x);
         end else begin
            e = expected_centres.pop_front();
            if (rsp_new_a_x !== e.a_x) report_mismatch("new_a_x", rsp_new_a_x, e.a_x);
            if (rsp_new_a_y !== e.a_y) report_mismatch("new_a_y", rsp_new_a_y, e.a_y);
            if (rsp_new_b_x !== e.b_x) report_mismatch("new_b_x", rsp_new_b_x, e.b_x);
            if (rsp_new_b_y !== e.b_y) report_mismatch("new_b_y", rsp_new_b_y, e.b_y);
         end
      end
   end

   // Count cycles with no request taken and no result seen; end the run if it hangs.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired");
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   function automatic push_req_type make_req(bit sa, bit sb, longint ax, longint ay,
                                             longint bx, longint by, longint aw,
                                             longint ah, longint bw, longint bh,
                                             bit ma, bit mb);
      push_req_type r;
      r.shape_a = sa;
      r.shape_b = sb;
      r.a_x = ax[cpo_pkg::COORD_W-1:0];
      r.a_y = ay[cpo_pkg::COORD_W-1:0];
      r.b_x = bx[cpo_pkg::COORD_W-1:0];
      r.b_y = by[cpo_pkg::COORD_W-1:0];
      r.a_w = aw[cpo_pkg::SIZE_W-1:0];
      r.a_h = ah[cpo_pkg::SIZE_W-1:0];
      r.b_w = bw[cpo_pkg::SIZE_W-1:0];
      r.b_h = bh[cpo_pkg::SIZE_W-1:0];
      r.mov_a = ma;
      r.mov_b = mb;
      return r;
   endfunction

   localparam longint ONE  = 65536;
   localparam longint CMAX = 2147483647;
   localparam longint CMIN = -2147483648;
   localparam longint SMAX = 2147483647;

   task automatic test_circle_pairs();
      // overlap per movable mix, no contact, coincident or near centres, saturation
      send_request(make_req(0, 0, 0, 0, ONE, ONE / 2, ONE, 0, ONE, 0, 1, 1));
      send_request(make_req(0, 0, 0, 0, ONE, ONE / 2, ONE, 0, ONE, 0, 1, 0));
      send_request(make_req(0, 0, 0, 0, -ONE, ONE / 3, ONE, 0, ONE, 0, 0, 1));
      send_request(make_req(0, 0, 0, 0, ONE, ONE, ONE, 0, ONE, 0, 0, 0));
      send_request(make_req(0, 0, 0, 0, 5 * ONE, 0, ONE, 0, ONE, 0, 1, 1));
      send_request(make_req(0, 0, 7, 7, 7, 7, ONE, 0, ONE, 0, 1, 1));
      send_request(make_req(0, 0, 0, 0, 6, 0, ONE, 0, ONE, 0, 1, 1));
      send_request(make_req(0, 0, CMAX, CMAX, CMIN, CMIN, SMAX, SMAX, SMAX, SMAX, 1, 1));
      send_request(make_req(0, 0, CMAX - 5, 0, CMAX - ONE, 0, SMAX, 0, SMAX, 0, 1, 0));
   endtask

   task automatic test_box_pairs();
      send_request(make_req(1, 1, 0, 0, ONE, ONE / 4, 4 * ONE, 4 * ONE, 2 * ONE,
                            2 * ONE, 1, 1));
      send_request(make_req(1, 1, 0, 0, ONE / 4, -ONE, 4 * ONE, 4 * ONE, 2 * ONE,
                            2 * ONE, 1, 0));
      send_request(make_req(1, 1, 5, 5, 5, 5, 3 * ONE, 3 * ONE, ONE, ONE, 0, 1));
      send_request(make_req(1, 1, 0, 0, 10 * ONE, 0, ONE, ONE, ONE, ONE, 1, 1));
      send_request(make_req(1, 1, CMIN, CMIN, CMIN + 3, CMIN + 1, SMAX, SMAX, SMAX,
                            SMAX, 1, 0));
      send_request(make_req(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1));
   endtask

   task automatic test_circle_box_pairs();
      send_request(make_req(0, 1, 3 * ONE, ONE / 2, 0, 0, 2 * ONE, 0, 4 * ONE,
                            2 * ONE, 1, 1));
      send_request(make_req(1, 0, 0, 0, -3 * ONE, 2 * ONE, 4 * ONE, 2 * ONE,
                            2 * ONE, 0, 1, 0));
      send_request(make_req(1, 0, 0, 0, 3 * ONE, 0, 4 * ONE, 2 * ONE, 2 * ONE, 0,
                            0, 1));
      // centre inside the box: no push
      send_request(make_req(0, 1, ONE / 2, 0, 0, 0, ONE, 0, 4 * ONE, 4 * ONE, 1, 1));
      send_request(make_req(0, 1, CMAX, CMAX, CMIN, CMIN, SMAX, 0, SMAX, SMAX, 1, 1));
      send_request(make_req(1, 0, CMAX, CMIN, CMAX - ONE, CMIN + 9, SMAX, SMAX, SMAX,
                            SMAX, 1, 1));
   endtask

   // signed random offset of random magnitude so that shapes often touch
   function automatic longint near_offset();
      return longint'($signed($urandom)) >>> $urandom_range(31, 8);
   endfunction

   function automatic longint rand_size();
      return longint'($urandom >> $urandom_range(31, 9));
   endfunction

   task automatic test_random(int count, int sender_idle);
      push_req_type r;
      longint ax, ay;
      idle_pct = sender_idle;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(7) == 0) begin
            // noise: every field at full random width
            r = make_req(1'($urandom), 1'($urandom), $signed($urandom), $signed($urandom),
                         $signed($urandom), $signed($urandom), $urandom, $urandom,
                         $urandom, $urandom, 1'($urandom), 1'($urandom));
         end else begin
            ax = longint'($signed($urandom));
            ay = longint'($signed($urandom));
            r = make_req(1'($urandom), 1'($urandom), ax, ay,
                         ax + near_offset(), ay + near_offset(),
                         rand_size(), rand_size(), rand_size(), rand_size(),
                         1'($urandom), 1'($urandom));
            // keep both centres inside the coordinate range most of the time
            if ($urandom_range(3) != 0) begin
               r.b_x = cpo_pkg::COORD_W'(ax + near_offset() / 4);
               r.b_y = cpo_pkg::COORD_W'(ay + near_offset() / 4);
            end
         end
         send_request(r);
      end
   endtask

   initial begin
      reset                 = 1'b1;
      start                 = 1'b0;
      req_shape_a           = 1'b0;
      req_shape_b           = 1'b0;
      req_a_x               = '0;
      req_a_y               = '0;
      req_b_x               = '0;
      req_b_y               = '0;
      req_a_width_or_radius = '0;
      req_a_height          = '0;
      req_b_width_or_radius = '0;
      req_b_height          = '0;
      req_movable_a         = 1'b0;
      req_movable_b         = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_circle_pairs();
      test_box_pairs();
      test_circle_box_pairs();
      wait_drained();

      test_random(150, 20);
      wait_drained();
      test_random(150, 69);
      test_random(150, 0);
      wait_drained();

      repeat (PIPE_LATENCY + 10) @(posedge clock);
      if (error_count == 0 && expected_centres.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
src/cpo_pkg.sv
src/cpo_front.sv
src/cpo_sqrt.sv
src/cpo_div.sv
src/collision_push_out_2d_unit.sv
dv/tb.sv
